// ===== hdl/sss_pkg.sv =====
// Shared types and constants for the smooth source switch.
package sss_pkg;

  localparam int SampleWidth  = 32;
  localparam int NumSources   = 4;
  localparam int SelWidth     = 2;
  localparam int CfgWidth     = 31;
  localparam int SrcCntWidth  = 3;
  localparam int CfgIdxWidth  = 2;
  localparam int RemWidth     = 33;

  localparam logic [CfgWidth-1:0]    TransitionTimeRst = 31'd65536;
  localparam logic [CfgWidth-1:0]    StepTimeRst       = 31'd1311;
  localparam logic [CfgWidth-1:0]    EpsilonRst        = 31'd655;
  localparam logic [SrcCntWidth-1:0] SourcesInUseRst   = 3'd4;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgTransitionTime = 2'd0,
    CfgStepTime       = 2'd1,
    CfgEpsilon        = 2'd2,
    CfgSourcesInUse   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusStepZero = 2'd1,
    StatusSelRange = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [SampleWidth-1:0] value_0;
    logic signed [SampleWidth-1:0] value_1;
    logic signed [SampleWidth-1:0] value_2;
    logic signed [SampleWidth-1:0] value_3;
    logic [SelWidth-1:0]           selected;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleWidth-1:0] output_sample;
    status_e                       status;
    logic                          in_transition;
  } out_item_t;

endpackage

// ===== hdl/smooth_source_switch.sv =====
// Smooth source switch: ramped transfer between selected sources, one shared adder.
// Sequence: pass-through and errors go straight to StFin; an early snap runs StDiff, StAbs and
//   StCheck; a full jump adds StDec; a scaled step adds 31 multiply and 32 divide steps, StApply, StDec.
// in_ready_o is high only while idle, so a new transaction is not taken until the last one is through.
// The result sits in an output register, so the next transaction is taken while it waits.
// Reset: asynchronous, active low; configuration returns to its defaults, no prior selection.
module smooth_source_switch
  import sss_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  in_item_t               in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output out_item_t              out_data_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  logic [CfgWidth-1:0]    cfg_data_i
);

  localparam int SW      = SampleWidth;
  localparam int AW      = SW + 2;
  localparam int PW      = SW + CfgWidth;
  localparam int MaxIter = (SW > CfgWidth) ? SW : CfgWidth;
  localparam int CntW    = $clog2(MaxIter + 1);

  typedef enum logic [3:0] {
    StIdle, StDiff, StAbs, StCheck, StMul, StDiv, StApply, StDec, StFin
  } state_e;

  // configuration
  logic [CfgWidth-1:0]    trans_q, step_q, eps_q;
  logic [SrcCntWidth-1:0] srcs_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trans_q <= TransitionTimeRst;
      step_q  <= StepTimeRst;
      eps_q   <= EpsilonRst;
      srcs_q  <= SourcesInUseRst;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgTransitionTime: trans_q <= cfg_data_i;
        CfgStepTime:       step_q  <= cfg_data_i;
        CfgEpsilon:        eps_q   <= cfg_data_i;
        CfgSourcesInUse:   srcs_q  <= cfg_data_i[SrcCntWidth-1:0];
        default: ;
      endcase
    end
  end

  // datapath state
  state_e                  state_q;
  logic                    have_q;
  logic [SelWidth-1:0]     last_q;
  logic signed [SW-1:0]    out_q;
  logic signed [RemWidth-1:0] rem_q;
  logic signed [SW-1:0]    target_q;
  logic [SW:0]             diff_q;
  logic                    neg_q;
  logic [PW-1:0]           prod_q;
  logic [CntW-1:0]         cnt_q;
  status_e                 status_q;
  out_item_t               res_q;
  logic                    out_valid_q;

  // input side decode
  logic signed [SW-1:0] src [NumSources];
  logic [SelWidth-1:0]  sel;
  logic                 sel_bad;
  status_e              in_status;
  logic signed [RemWidth-1:0] rem_new;
  logic                 rem_new_pos;
  logic                 rem_pos;
  logic                 accept;

  assign src[0] = in_data_i.value_0;
  assign src[1] = in_data_i.value_1;
  assign src[2] = in_data_i.value_2;
  assign src[3] = in_data_i.value_3;
  assign sel    = in_data_i.selected;

  assign sel_bad = ({1'b0, sel} >= srcs_q) || (32'(sel) >= NumSources);

  always_comb begin
    if (step_q == '0) begin
      in_status = StatusStepZero;
    end else if (sel_bad) begin
      in_status = StatusSelRange;
    end else begin
      in_status = StatusOk;
    end
  end

  assign rem_new     = (last_q != sel) ? RemWidth'(trans_q) : rem_q;
  assign rem_new_pos = !rem_new[RemWidth-1] && (rem_new != '0);
  assign rem_pos     = !rem_q[RemWidth-1] && (rem_q != '0);

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  // shared adder/subtractor
  logic [AW-1:0]        alu_a, alu_b, alu_res;
  logic                 alu_sub;
  logic [SW-1:0]        mag;
  logic [SW-1:0]        prod_hi;
  logic [CfgWidth-1:0]  div_r;
  logic [CfgWidth:0]    div_r2;
  logic                 div_take;
  logic [CfgWidth-1:0]  div_rnew;

  assign mag      = diff_q[SW-1:0];
  assign prod_hi  = prod_q[PW-1:CfgWidth];
  assign div_r    = prod_q[PW-1:SW];
  assign div_r2   = {div_r, prod_q[SW-1]};
  assign div_take = !alu_res[AW-1];
  assign div_rnew = div_take ? alu_res[CfgWidth-1:0] : div_r2[CfgWidth-1:0];

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      StDiff: begin
        alu_a   = {{(AW-SW){target_q[SW-1]}}, target_q};
        alu_b   = {{(AW-SW){out_q[SW-1]}}, out_q};
        alu_sub = 1'b1;
      end
      StAbs: begin
        alu_b   = {{(AW-SW-1){diff_q[SW]}}, diff_q};
        alu_sub = diff_q[SW];
      end
      StMul: begin
        alu_a = AW'(prod_hi);
        alu_b = prod_q[0] ? AW'(mag) : '0;
      end
      StDiv: begin
        alu_a   = AW'(div_r2);
        alu_b   = AW'(rem_q[CfgWidth-1:0]);
        alu_sub = 1'b1;
      end
      StApply: begin
        alu_a   = {{(AW-SW){out_q[SW-1]}}, out_q};
        alu_b   = AW'(prod_q[SW-1:0]);
        alu_sub = neg_q;
      end
      StDec: begin
        alu_a   = {{(AW-RemWidth){rem_q[RemWidth-1]}}, rem_q};
        alu_b   = AW'(step_q);
        alu_sub = 1'b1;
      end
      default: ;
    endcase
    alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + AW'(alu_sub);
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      have_q      <= 1'b0;
      last_q      <= '0;
      out_q       <= '0;
      rem_q       <= '0;
      target_q    <= '0;
      diff_q      <= '0;
      neg_q       <= 1'b0;
      prod_q      <= '0;
      cnt_q       <= '0;
      status_q    <= StatusOk;
      res_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // StFin reloads the output register itself
      if (out_valid_q && out_ready_i && (state_q != StFin)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (accept) begin
            status_q <= in_status;
            target_q <= src[sel];
            if (in_status == StatusOk) begin
              have_q <= 1'b1;
              last_q <= sel;
              if (!have_q) begin
                out_q   <= src[sel];
                rem_q   <= '0;
                state_q <= StFin;
              end else begin
                rem_q <= rem_new;
                if (rem_new_pos) begin
                  state_q <= StDiff;
                end else begin
                  out_q   <= src[sel];
                  state_q <= StFin;
                end
              end
            end else begin
              state_q <= StFin;
            end
          end
        end
        StDiff: begin
          diff_q  <= alu_res[SW:0];
          neg_q   <= alu_res[SW];
          state_q <= StAbs;
        end
        StAbs: begin
          diff_q  <= alu_res[SW:0];
          state_q <= StCheck;
        end
        StCheck: begin
          if (mag <= SW'(eps_q)) begin
            out_q   <= target_q;
            rem_q   <= '0;
            state_q <= StFin;
          end else if (RemWidth'(step_q) >= rem_q) begin
            out_q   <= target_q;
            state_q <= StDec;
          end else begin
            prod_q  <= {SW'(0), step_q};
            cnt_q   <= '0;
            state_q <= StMul;
          end
        end
        StMul: begin
          // right-shift multiply: mag * step_time
          prod_q <= {alu_res[SW:0], prod_q[CfgWidth-1:1]};
          if (cnt_q == CntW'(CfgWidth - 1)) begin
            cnt_q   <= '0;
            state_q <= StDiv;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        StDiv: begin
          // restoring divide; high part of the product is already below rem
          prod_q <= {div_rnew, prod_q[SW-2:0], div_take};
          if (cnt_q == CntW'(SW - 1)) begin
            cnt_q   <= '0;
            state_q <= StApply;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        StApply: begin
          out_q   <= alu_res[SW-1:0];
          state_q <= StDec;
        end
        StDec: begin
          rem_q   <= alu_res[RemWidth-1:0];
          state_q <= StFin;
        end
        StFin: begin
          if (!out_valid_q || out_ready_i) begin
            res_q.status <= status_q;
            if (status_q == StatusOk) begin
              res_q.output_sample <= out_q;
              res_q.in_transition <= rem_pos;
            end else begin
              res_q.output_sample <= '0;
              res_q.in_transition <= 1'b0;
            end
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

`ifndef SYNTHESIS
  a_err_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != StatusOk) |->
      (out_data_o.output_sample == '0) && !out_data_o.in_transition)
    else $error("error result carries a sample or transition flag");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("input taken again before sequencer finished");

  a_have_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(have_q))
    else $error("selection history lost");

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMul) || (state_q == StDiv) |-> cnt_q < CntW'(MaxIter))
    else $error("iteration counter overran");
`endif

endmodule

// ===== bench/smooth_source_switch_test.sv =====
// Self-checking testbench for the smooth source switch: directed cases, then random phases.
`timescale 1ns / 1ps

module smooth_source_switch_test;
  import sss_pkg::*;

  localparam logic signed [SampleWidth-1:0] MaxSample = 32'sh7fff_ffff;
  localparam logic signed [SampleWidth-1:0] MinSample = 32'sh8000_0000;
  localparam logic [CfgWidth-1:0]           MaxCfg    = '1;
  localparam int                            DrainCycles = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  cfg_idx_e            cfg_index = CfgTransitionTime;
  logic [CfgWidth-1:0] cfg_data = '0;

  // register copies, reset values
  logic [CfgWidth-1:0]    ramp_time_cfg = TransitionTimeRst;
  logic [CfgWidth-1:0]    step_time_cfg = StepTimeRst;
  logic [CfgWidth-1:0]    tol_cfg       = EpsilonRst;
  logic [SrcCntWidth-1:0] src_cnt_cfg   = SourcesInUseRst;

  // switch state
  bit          have_sel   = 1'b0;
  logic [1:0]  last_sel   = '0;
  longint      smooth_out = 0;
  longint      ramp_left  = 0;

  in_item_t  pending_items[$];
  out_item_t expected_outputs[$];

  int idle_level = 0;
  int in_gap = 0;
  int out_gap = 0;
  int mismatches = 0;
  int items_accepted = 0;
  int results_seen = 0;
  int ramp_results = 0;
  int error_results = 0;
  int settings_written = 0;

  smooth_source_switch u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Expected result for one transaction; advances the switch state.
  function automatic out_item_t next_switch_output(input in_item_t it);
    out_item_t res;
    logic signed [SampleWidth-1:0] target;
    longint diff;
    longint mag;
    longint step_mag;
    res = '0;
    res.status = StatusOk;
    if (step_time_cfg == '0) begin
      res.status = StatusStepZero;
      return res;
    end
    if (it.selected >= src_cnt_cfg || int'(it.selected) >= NumSources) begin
      res.status = StatusSelRange;
      return res;
    end
    case (it.selected)
      2'd0: target = it.value_0;
      2'd1: target = it.value_1;
      2'd2: target = it.value_2;
      default: target = it.value_3;
    endcase
    if (!have_sel) begin
      have_sel = 1'b1;
      ramp_left = 0;
      smooth_out = longint'(target);
    end else begin
      if (last_sel != it.selected) ramp_left = longint'(ramp_time_cfg);
      if (ramp_left > 0) begin
        diff = longint'(target) - smooth_out;
        mag = (diff < 0) ? -diff : diff;
        if (mag <= longint'(tol_cfg)) begin
          smooth_out = longint'(target);
          ramp_left = 0;
        end else begin
          if (longint'(step_time_cfg) >= ramp_left) begin
            smooth_out = longint'(target);
          end else begin
            // |diff| < 2^32 and step < 2^31, so the product fits
            step_mag = (mag * longint'(step_time_cfg)) / ramp_left;
            smooth_out = smooth_out + ((diff < 0) ? -step_mag : step_mag);
          end
          ramp_left = ramp_left - longint'(step_time_cfg);
        end
      end else begin
        smooth_out = longint'(target);
      end
    end
    last_sel = it.selected;
    res.output_sample = smooth_out[SampleWidth-1:0];
    res.in_transition = (ramp_left > 0);
    return res;
  endfunction

  function automatic bit idle_hit();
    if (idle_level == 0) return 1'b0;
    return $urandom_range(0, (idle_level == 1) ? 9 : 2) == 0;
  endfunction

  task automatic report_mismatch(input string field, input longint got_v, input longint want_v);
    if (mismatches < 50)
      $display("mismatch in %s at result %0d: got %0d, expected %0d",
               field, results_seen, got_v, want_v);
    mismatches++;
  endtask

  // driver: one transaction per handshake, predictor runs on acceptance
  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      expected_outputs.push_back(next_switch_output(in_item));
      items_accepted++;
    end
    if (!in_valid || in_ready) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_item <= pending_items.pop_front();
        in_valid <= 1'b1;
        if (idle_hit()) in_gap = $urandom_range(1, 19);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (out_valid && out_ready) begin
      if (expected_outputs.size() == 0) begin
        report_mismatch("unexpected result", out_data.output_sample, 0);
      end else begin
        want = expected_outputs.pop_front();
        if (out_data.output_sample !== want.output_sample)
          report_mismatch("output_sample", out_data.output_sample, want.output_sample);
        if (out_data.status !== want.status)
          report_mismatch("status", int'(out_data.status), int'(want.status));
        if (out_data.in_transition !== want.in_transition)
          report_mismatch("in_transition", out_data.in_transition, want.in_transition);
        if (want.in_transition) ramp_results++;
        if (want.status != StatusOk) error_results++;
      end
      results_seen++;
    end
    if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (idle_hit()) out_gap = $urandom_range(1, 19);
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgWidth-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CfgTransitionTime: ramp_time_cfg = val;
      CfgStepTime:       step_time_cfg = val;
      CfgEpsilon:        tol_cfg = val;
      CfgSourcesInUse:   src_cnt_cfg = val[SrcCntWidth-1:0];
      default: ;
    endcase
    settings_written++;
  endtask

  task automatic queue_item(input logic signed [SampleWidth-1:0] a, b, c, d,
                            input logic [SelWidth-1:0] s);
    in_item_t it;
    it.value_0 = a;
    it.value_1 = b;
    it.value_2 = c;
    it.value_3 = d;
    it.selected = s;
    pending_items.push_back(it);
  endtask

  // block is idle once everything sent has come back, plus its latency
  task automatic drain();
    @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_outputs.size() != 0)
      @(negedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic logic signed [SampleWidth-1:0] pick_sample(input int mode);
    case (mode)
      0: return int'($urandom_range(0, 1 << 21)) - (1 << 20);
      1: return $urandom;
      2: begin
        case ($urandom_range(0, 3))
          0: return MaxSample;
          1: return MinSample;
          2: return -1;
          default: return 0;
        endcase
      end
      default: return int'($urandom_range(0, 1 << 28)) - (1 << 27);
    endcase
  endfunction

  task automatic write_random_settings();
    logic [CfgWidth-1:0]    st;
    logic [CfgWidth-1:0]    tt;
    logic [CfgWidth-1:0]    eps;
    logic [SrcCntWidth-1:0] src;
    longint span;
    case ($urandom_range(0, 11))
      0: st = '0;
      1: st = MaxCfg;
      2: st = CfgWidth'($urandom);
      default: st = CfgWidth'($urandom_range(1, 4000));
    endcase
    case ($urandom_range(0, 9))
      0: tt = '0;
      1: tt = MaxCfg;
      2: tt = CfgWidth'($urandom);
      default: begin
        span = longint'(st) * longint'($urandom_range(1, 40)) + longint'($urandom_range(0, 1000));
        tt = (span > longint'(MaxCfg)) ? MaxCfg : CfgWidth'(span);
      end
    endcase
    case ($urandom_range(0, 9))
      0: eps = '0;
      1: eps = MaxCfg;
      2: eps = CfgWidth'($urandom);
      default: eps = CfgWidth'($urandom_range(0, 70000));
    endcase
    src = ($urandom_range(0, 9) < 7) ? SrcCntWidth'(NumSources)
                                     : SrcCntWidth'($urandom_range(0, 7));
    write_reg(CfgStepTime, st);
    write_reg(CfgTransitionTime, tt);
    write_reg(CfgEpsilon, eps);
    write_reg(CfgSourcesInUse, CfgWidth'(src));
  endtask

  // mostly steady runs on one source with drifting samples; some noise
  task automatic queue_random_phase(input int n_items);
    int left;
    int run_len;
    int sel_max;
    int mode;
    int drift;
    logic [SelWidth-1:0] sel;
    logic signed [SampleWidth-1:0] v[4];
    left = n_items;
    while (left > 0) begin
      if ($urandom_range(0, 4) == 0) begin
        queue_item($urandom, $urandom, $urandom, $urandom, SelWidth'($urandom));
        left--;
      end else begin
        sel_max = (src_cnt_cfg == 0 || src_cnt_cfg > NumSources) ? NumSources - 1
                                                                 : src_cnt_cfg - 1;
        sel = SelWidth'($urandom_range(0, sel_max));
        mode = $urandom_range(0, 3);
        drift = $urandom_range(0, 3000);
        for (int k = 0; k < 4; k++) v[k] = pick_sample(mode);
        run_len = $urandom_range(1, 60);
        if (run_len > left) run_len = left;
        repeat (run_len) begin
          queue_item(v[0], v[1], v[2], v[3], sel);
          for (int k = 0; k < 4; k++)
            v[k] = v[k] + int'($urandom_range(0, 2 * drift)) - drift;
          left--;
        end
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // defaults: pass-through, snap at and inside the band, ramps to both extremes
    idle_level = 1;
    @(negedge clk);
    queue_item(1000, 1300, MaxSample, MinSample, 2'd0);
    queue_item(1000, 1300, MaxSample, MinSample, 2'd1);
    queue_item(645, 1300, MaxSample, MinSample, 2'd0);
    repeat (3) queue_item(645, 1300, MaxSample, MinSample, 2'd2);
    repeat (3) queue_item(645, 1300, MaxSample, MinSample, 2'd3);
    queue_item(-1, 0, 0, MinSample, 2'd3);
    drain();

    // ramp shorter than one step: full jump
    write_reg(CfgTransitionTime, 31'd1000);
    write_reg(CfgEpsilon, '0);
    @(negedge clk);
    queue_item(7, -7, 0, 0, 2'd0);
    queue_item(7, -7, 0, 0, 2'd1);
    drain();

    // no ramp at all
    write_reg(CfgTransitionTime, '0);
    @(negedge clk);
    queue_item(1, 2, 3, 4, 2'd2);
    queue_item(1, 2, 3, 4, 2'd0);
    drain();

    // selection out of range, then step time zero with the selection in range
    write_reg(CfgSourcesInUse, 31'd2);
    @(negedge clk);
    queue_item(1, 2, 3, 4, 2'd3);
    queue_item(1, 2, 3, 4, 2'd2);
    queue_item(1, 2, 3, 4, 2'd1);
    drain();
    write_reg(CfgSourcesInUse, 31'd0);
    @(negedge clk);
    queue_item(1, 2, 3, 4, 2'd0);
    drain();
    write_reg(CfgSourcesInUse, 31'd7);
    write_reg(CfgStepTime, '0);
    @(negedge clk);
    queue_item(1, 2, 3, 4, 2'd3);
    drain();

    // largest settings: wide band, then a full-scale swing
    write_reg(CfgStepTime, MaxCfg);
    write_reg(CfgTransitionTime, MaxCfg);
    write_reg(CfgEpsilon, MaxCfg);
    @(negedge clk);
    queue_item(MaxSample, MinSample, 0, 0, 2'd0);
    queue_item(MaxSample, MinSample, 0, 0, 2'd1);
    drain();
    write_reg(CfgStepTime, 31'd1);
    @(negedge clk);
    repeat (2) queue_item(MaxSample, MinSample, 0, 0, 2'd0);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      idle_level = (ph >= 8) ? 0 : $urandom_range(0, 2);
      write_random_settings();
      @(negedge clk);
      queue_random_phase(188);
      drain();
    end

    $display("Sent %0d transactions across %0d register writes;", items_accepted,
             settings_written);
    $display("%0d results came mid-ramp and %0d carried an error status.", ramp_results,
             error_results);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #25_000_000;
    $display("timeout with %0d results outstanding", expected_outputs.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
